/* sv/aeaa_pkg.sv */
// Shared widths, types and the arctangent table of the elevation-angle averager.
package aeaa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  localparam int RAW_W       = 16;
  localparam int PRESCALE_SH = 24;
  localparam int XW          = 44;  // prescaled axes plus CORDIC gain and guard
  localparam int XPAD        = XW - RAW_W - PRESCALE_SH;
  localparam int AW          = 26;  // angle, degrees * 2^16
  localparam int ATAN_W      = 23;
  localparam int ANG_W       = 17;  // Q8.8 degrees
  localparam int SUM_W       = 25;
  localparam int CNT_W       = 8;
  localparam int ITER_W      = 5;
  localparam int DIV_N       = SUM_W;

  localparam logic signed [AW-1:0]    DEG90     = AW'(90 * 65536);
  localparam logic signed [AW-1:0]    RND_HALF  = AW'(128);
  localparam logic signed [ANG_W-1:0] OUT_LIMIT = 17'sd46080;

  localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_N - 1);
  localparam logic [ITER_W-1:0] DIV_LAST    = ITER_W'(DIV_N - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ACCUM,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              accum;
    logic              div_step;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } status_t;

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      5'd18:   v = 23'd14;
      5'd19:   v = 23'd7;
      5'd20:   v = 23'd4;
      5'd21:   v = 23'd2;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/aeaa_ctrl.sv */
// Sequencer of the elevation-angle averager: CORDIC, accumulate, divide, write.
module aeaa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  aeaa_pkg::status_t   status,
  output aeaa_pkg::cmd_t      cmd
);

  aeaa_pkg::state_t                  state, state_next;
  logic [aeaa_pkg::ITER_W-1:0]       cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aeaa_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    unique case (state)
      aeaa_pkg::ST_IDLE: begin
        if (in_valid) state_next = aeaa_pkg::ST_CORDIC;
      end
      aeaa_pkg::ST_CORDIC: begin
        if (cnt == aeaa_pkg::CORDIC_LAST) begin
          state_next = aeaa_pkg::ST_ACCUM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      aeaa_pkg::ST_ACCUM: begin
        state_next = status.emit ? aeaa_pkg::ST_DIVIDE : aeaa_pkg::ST_IDLE;
      end
      aeaa_pkg::ST_DIVIDE: begin
        if (cnt == aeaa_pkg::DIV_LAST) begin
          state_next = aeaa_pkg::ST_WRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      aeaa_pkg::ST_WRITE: begin
        if (status.out_free) state_next = aeaa_pkg::ST_IDLE;
      end
      default: state_next = aeaa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = (state != aeaa_pkg::ST_IDLE);
    cmd.load         = (state == aeaa_pkg::ST_IDLE) && in_valid;
    cmd.cordic_step  = (state == aeaa_pkg::ST_CORDIC);
    cmd.iter         = cnt;
    cmd.accum        = (state == aeaa_pkg::ST_ACCUM);
    cmd.div_step     = (state == aeaa_pkg::ST_DIVIDE);
    cmd.out_load     = (state == aeaa_pkg::ST_WRITE) && status.out_free;
  end

endmodule

/* sv/aeaa_dpath.sv */
// Datapath: prerotation, shared CORDIC stage, window sum, serial divider, output register.
module aeaa_dpath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [aeaa_pkg::CNT_W-1:0]              cfg_wr_data,
  input  logic signed [aeaa_pkg::RAW_W-1:0]       raw_x,
  input  logic signed [aeaa_pkg::RAW_W-1:0]       raw_z,
  input  aeaa_pkg::cmd_t                          cmd,
  output aeaa_pkg::status_t                       status,
  input  logic                                    out_stall,
  output logic                                    out_valid,
  output logic signed [aeaa_pkg::ANG_W-1:0]       elevation
);

  logic [aeaa_pkg::CNT_W-1:0]          sample_count;
  logic [aeaa_pkg::CNT_W-1:0]          limit;

  logic signed [aeaa_pkg::XW-1:0]      xe, ze, x_load, z_load;
  logic signed [aeaa_pkg::AW-1:0]      ang_load;
  logic signed [aeaa_pkg::XW-1:0]      x, z, xs, zs;
  logic signed [aeaa_pkg::AW-1:0]      ang, at;
  logic                                zero_in;

  logic signed [aeaa_pkg::AW-1:0]      ang_rnd, q_wide;
  logic signed [aeaa_pkg::ANG_W-1:0]   q;
  logic signed [aeaa_pkg::SUM_W-1:0]   angle_sum, sum_new;
  logic [aeaa_pkg::CNT_W-1:0]          samples_taken, taken_next;

  logic                                neg;
  logic [aeaa_pkg::SUM_W-1:0]          quo, quo_signed;
  logic [aeaa_pkg::CNT_W-1:0]          rem, divisor;
  logic [aeaa_pkg::CNT_W:0]            rem_sh, rem_diff;

  // config register; zero behaves as one
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= aeaa_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      sample_count <= cfg_wr_data;
    end
  end

  assign limit = (sample_count == '0) ? aeaa_pkg::CNT_W'(1) : sample_count;

  // prescale by 2^24, then turn left half-plane vectors by 90 degrees
  assign xe = {{aeaa_pkg::XPAD{raw_x[aeaa_pkg::RAW_W-1]}}, raw_x,
               {aeaa_pkg::PRESCALE_SH{1'b0}}};
  assign ze = {{aeaa_pkg::XPAD{raw_z[aeaa_pkg::RAW_W-1]}}, raw_z,
               {aeaa_pkg::PRESCALE_SH{1'b0}}};

  always_comb begin
    x_load   = xe;
    z_load   = ze;
    ang_load = '0;
    if (xe[aeaa_pkg::XW-1]) begin
      if (!ze[aeaa_pkg::XW-1]) begin
        x_load   = ze;
        z_load   = -xe;
        ang_load = aeaa_pkg::DEG90;
      end else begin
        x_load   = -ze;
        z_load   = xe;
        ang_load = -aeaa_pkg::DEG90;
      end
    end
  end

  assign xs = x >>> cmd.iter;
  assign zs = z >>> cmd.iter;
  assign at = $signed(aeaa_pkg::AW'(aeaa_pkg::atan_q16(cmd.iter)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x       <= x_load;
      z       <= z_load;
      ang     <= ang_load;
      zero_in <= (raw_x == '0) && (raw_z == '0);
    end else if (cmd.cordic_step) begin
      if (!z[aeaa_pkg::XW-1]) begin
        x   <= x + zs;
        z   <= z - xs;
        ang <= ang + at;
      end else begin
        x   <= x - zs;
        z   <= z + xs;
        ang <= ang - at;
      end
    end
  end

  // round to Q8.8, halves up, and clamp; an all-zero input gives zero
  always_comb begin
    ang_rnd = ang + aeaa_pkg::RND_HALF;
    q_wide  = ang_rnd >>> 8;
    priority if (zero_in) begin
      q = '0;
    end else if (q_wide > aeaa_pkg::OUT_LIMIT) begin
      q = aeaa_pkg::OUT_LIMIT;
    end else if (q_wide < -aeaa_pkg::OUT_LIMIT) begin
      q = -aeaa_pkg::OUT_LIMIT;
    end else begin
      q = q_wide[aeaa_pkg::ANG_W-1:0];
    end
  end

  assign sum_new     = angle_sum + aeaa_pkg::SUM_W'(q);
  assign taken_next  = samples_taken + 1'b1;
  assign status.emit = (taken_next != '0) && (taken_next >= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_sum     <= '0;
      samples_taken <= '0;
    end else if (cmd.accum) begin
      if (status.emit) begin
        angle_sum     <= '0;
        samples_taken <= '0;
      end else begin
        angle_sum     <= sum_new;
        samples_taken <= taken_next;
      end
    end
  end

  // restoring divide of |sum| by the count, one quotient bit a beat
  assign rem_sh   = {rem, quo[aeaa_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      neg     <= sum_new[aeaa_pkg::SUM_W-1];
      quo     <= sum_new[aeaa_pkg::SUM_W-1] ? $unsigned(-sum_new) : $unsigned(sum_new);
      divisor <= taken_next;
      rem     <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_diff[aeaa_pkg::CNT_W-1:0];
        quo <= {quo[aeaa_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[aeaa_pkg::CNT_W-1:0];
        quo <= {quo[aeaa_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      elevation <= $signed(quo_signed[aeaa_pkg::ANG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule

/* sv/accel_elevation_angle_averager.sv */
// Top level of the elevation-angle averager: sequencer plus datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   input   | in        | in_valid/in_stall  | raw_x[15:0], raw_z[15:0]
//   output  | out       | out_valid/out_stall| elevation[16:0] (Q8.8 deg)
//   config  | in        | cfg_wr_en          | cfg_wr_data[7:0] sample_count
//
// A beat that closes no window runs accept, 16 steps on the one shared CORDIC
// stage, and accumulate. A beat that closes a window adds the 25 steps of the
// bit-serial divider and one write into the output register.
// The output register frees the sequencer unless a previous result is still
// stalled; the write waits there. Synchronous reset, no clearing pass.
module accel_elevation_angle_averager (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [aeaa_pkg::CNT_W-1:0]            cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [aeaa_pkg::RAW_W-1:0]     raw_x,
  input  logic signed [aeaa_pkg::RAW_W-1:0]     raw_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [aeaa_pkg::ANG_W-1:0]     elevation
);

  aeaa_pkg::cmd_t    cmd;
  aeaa_pkg::status_t status;

  aeaa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aeaa_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .raw_x       (raw_x),
    .raw_z       (raw_z),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .elevation   (elevation)
  );

endmodule

/* sv/aeaa_chk.sv */
// Port-level checker of the elevation-angle averager and its bind.
module aeaa_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [aeaa_pkg::ANG_W-1:0]   elevation
);

  // one beat at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  // a result appears only at the end of a busy stretch
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while idle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (elevation <= aeaa_pkg::OUT_LIMIT) && (elevation >= -aeaa_pkg::OUT_LIMIT))
    else $error("elevation out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(elevation))
    else $error("stalled result changed");

endmodule

bind accel_elevation_angle_averager aeaa_chk u_aeaa_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .elevation (elevation)
);
